[design/daf_pkg.sv]
// shared types, ascii constants and the double-dabble step for the decimal formatter
package daf_pkg;

    localparam int BIN_W      = 17;
    localparam int BCD_DIGITS = 5;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int DD_W       = BCD_W + BIN_W;

    localparam logic [BIN_W-1:0] VALUE_MAX = 17'd99999;

    localparam logic [7:0] ASCII_ZERO   = 8'd48;
    localparam logic [7:0] ASCII_BLANK  = 8'd32;
    localparam logic [7:0] ASCII_POINT  = 8'h2E;
    localparam logic [7:0] ASCII_DOLLAR = 8'h24;
    localparam logic [7:0] ASCII_C      = 8'h43;

    typedef enum logic [1:0] {
        KIND_FIVE    = 2'd0,
        KIND_ONE_DEC = 2'd1,
        KIND_TWO_DEC = 2'd2,
        KIND_TEMP    = 2'd3
    } t_kind;

    // bcd digits in the upper part, remaining binary bits in the lower part
    typedef logic [DD_W-1:0] t_dd;

    typedef struct packed {
        t_kind kind;
        logic  ovf;
        t_dd   sh;
    } t_stage;

    // one shift-add-3 step
    function automatic t_dd dd_step(input t_dd s);
        t_dd a;
        a = s;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (a[BIN_W + 4*i +: 4] >= 4'd5) begin
                a[BIN_W + 4*i +: 4] = a[BIN_W + 4*i +: 4] + 4'd3;
            end
        end
        return {a[DD_W-2:0], 1'b0};
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        return ASCII_ZERO + {4'd0, d};
    endfunction

endpackage

[design/decimal_ascii_formatter.sv]
// decimal ascii formatter: saturating binary to five-character display field
//
// input channel (i_valid / o_ready) carries a format selector i_kind and a
// 17-bit unsigned i_value; output channel (o_valid / i_ready) returns five
// ascii characters o_char_0 (leftmost) .. o_char_4 plus o_overflow, which is
// set when the value was above 99999 and was clamped to 99999.
// one result leaves for every request that enters, in order.
// each request passes a saturate stage, three double-dabble stages (6, 6 and
// 5 shift-add-3 steps of the 17 in total) and the character formatting stage,
// which is the output register. throughput is one request per cycle while
// i_ready does not stall the output; the double-dabble stages set the depth.
// each stage moves when it is empty or its successor moves, so a stall at
// i_ready freezes the full stages, bubbles still fill, and nothing is lost
// or repeated; o_ready drops only when all five stages hold requests.
// reset (synchronous, active low) clears every valid bit; data is not reset.
module decimal_ascii_formatter
    import daf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [16:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_char_0,
    output logic [7:0]  o_char_1,
    output logic [7:0]  o_char_2,
    output logic [7:0]  o_char_3,
    output logic [7:0]  o_char_4,
    output logic        o_overflow
);

    // shift-add-3 steps done in each of the three conversion stages
    localparam int STEPS_A = 6;
    localparam int STEPS_B = 6;
    localparam int STEPS_C = BIN_W - STEPS_A - STEPS_B;

    localparam int NSTAGE = 5;

    // stage valid bits: 0 saturate, 1..3 conversion, 4 output
    logic [NSTAGE-1:0] r_vld;
    logic [NSTAGE-1:0] n_vld;
    logic [NSTAGE-1:0] en;

    t_stage r_st [0:3];
    t_stage n_st [0:3];

    logic [7:0] r_char [0:4];
    logic [7:0] n_char [0:4];
    logic       r_ovf;

    logic [BIN_W-1:0] v_sat;
    logic [3:0]       d4, d3, d2, d1, d0;
    logic             z4, z43, z432;

    // advance enables, from the output back to the input
    always_comb begin
        en[NSTAGE-1] = !r_vld[NSTAGE-1] || i_ready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_ready = en[0];

    always_comb begin
        n_vld[0] = i_valid;
        for (int k = 1; k < NSTAGE; k++) begin
            n_vld[k] = r_vld[k-1];
        end
    end

    // saturate stage
    always_comb begin
        v_sat = (i_value > VALUE_MAX) ? VALUE_MAX : i_value;
        n_st[0].kind = t_kind'(i_kind);
        n_st[0].ovf  = (i_value > VALUE_MAX);
        n_st[0].sh   = {{BCD_W{1'b0}}, v_sat};
    end

    // conversion stages
    always_comb begin
        n_st[1] = r_st[0];
        for (int i = 0; i < STEPS_A; i++) begin
            n_st[1].sh = dd_step(n_st[1].sh);
        end
    end

    always_comb begin
        n_st[2] = r_st[1];
        for (int i = 0; i < STEPS_B; i++) begin
            n_st[2].sh = dd_step(n_st[2].sh);
        end
    end

    always_comb begin
        n_st[3] = r_st[2];
        for (int i = 0; i < STEPS_C; i++) begin
            n_st[3].sh = dd_step(n_st[3].sh);
        end
    end

    // format stage: digits taken from the finished bcd field
    assign d4 = r_st[3].sh[BIN_W + 16 +: 4];
    assign d3 = r_st[3].sh[BIN_W + 12 +: 4];
    assign d2 = r_st[3].sh[BIN_W + 8  +: 4];
    assign d1 = r_st[3].sh[BIN_W + 4  +: 4];
    assign d0 = r_st[3].sh[BIN_W      +: 4];

    // leading-zero blanking: value below 10000, 1000, 100
    assign z4   = (d4 == 4'd0);
    assign z43  = z4 && (d3 == 4'd0);
    assign z432 = z43 && (d2 == 4'd0);

    always_comb begin
        case (r_st[3].kind)
            KIND_FIVE: begin
                n_char[0] = z4   ? ASCII_BLANK : digit_char(d4);
                n_char[1] = z43  ? ASCII_BLANK : digit_char(d3);
                n_char[2] = z432 ? ASCII_BLANK : digit_char(d2);
                n_char[3] = digit_char(d1);
                n_char[4] = digit_char(d0);
            end
            KIND_ONE_DEC: begin
                // ten-thousands dropped
                n_char[0] = z43  ? ASCII_BLANK : digit_char(d3);
                n_char[1] = z432 ? ASCII_BLANK : digit_char(d2);
                n_char[2] = digit_char(d1);
                n_char[3] = ASCII_POINT;
                n_char[4] = digit_char(d0);
            end
            KIND_TWO_DEC: begin
                n_char[0] = z43 ? ASCII_BLANK : digit_char(d3);
                n_char[1] = digit_char(d2);
                n_char[2] = ASCII_POINT;
                n_char[3] = digit_char(d1);
                n_char[4] = digit_char(d0);
            end
            KIND_TEMP: begin
                n_char[0] = z432 ? ASCII_BLANK : digit_char(d2);
                n_char[1] = digit_char(d1);
                n_char[2] = digit_char(d0);
                n_char[3] = ASCII_DOLLAR;
                n_char[4] = ASCII_C;
            end
            default: begin
                n_char[0] = ASCII_BLANK;
                n_char[1] = ASCII_BLANK;
                n_char[2] = ASCII_BLANK;
                n_char[3] = ASCII_BLANK;
                n_char[4] = ASCII_BLANK;
            end
        endcase
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTAGE; k++) begin
                if (en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    // data registers, no reset
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NSTAGE - 1; k++) begin
            if (en[k]) begin
                r_st[k] <= n_st[k];
            end
        end
        if (en[NSTAGE-1]) begin
            for (int c = 0; c < 5; c++) begin
                r_char[c] <= n_char[c];
            end
            r_ovf <= r_st[3].ovf;
        end
    end

    assign o_valid    = r_vld[NSTAGE-1];
    assign o_char_0   = r_char[0];
    assign o_char_1   = r_char[1];
    assign o_char_2   = r_char[2];
    assign o_char_3   = r_char[3];
    assign o_char_4   = r_char[4];
    assign o_overflow = r_ovf;

`ifndef SYNTHESIS
    // an empty output stage means the whole pipe can move
    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled while output stage empty");

    // rightmost character is always a digit or the temperature suffix
    a_last_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_char_4 >= 8'h30 && o_char_4 <= 8'h39) || o_char_4 == ASCII_C))
        else $error("rightmost character not a digit");

    // a saturated request shows nines in the rightmost digit place
    a_ovf_nines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |-> (o_char_4 == 8'h39 || o_char_4 == ASCII_C))
        else $error("overflow without saturated digits");
`endif

endmodule

[tb/decimal_ascii_formatter_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for the decimal ascii formatter with a field predictor
module decimal_ascii_formatter_tb;
    import daf_pkg::*;

    // five characters, leftmost in the top byte, plus the saturation flag
    typedef struct packed {
        logic [39:0] text;
        logic        ovf;
    } t_field;

    // one row of the directed table; typed rows carry their own answer
    typedef struct packed {
        t_kind       kind;
        logic [16:0] value;
        logic        typed;
        logic [39:0] text;
        logic        ovf;
    } t_row;

    localparam int DIRECTED_ROWS  = 25;
    localparam int RANDOM_PHASES  = 5;
    localparam int PHASE_REQUESTS = 230;
    localparam int DRAIN_CYCLES   = 12;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int PRINT_LIMIT    = 100;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_kind  = KIND_FIVE;
    logic [16:0] i_value = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_char_0;
    logic [7:0]  o_char_1;
    logic [7:0]  o_char_2;
    logic [7:0]  o_char_3;
    logic [7:0]  o_char_4;
    logic        o_overflow;

    t_field pending_fields[$];
    int     error_count  = 0;
    int     cycle_count  = 0;
    int     send_idle    = 0;
    int     recv_stall   = 0;

    // extremes, blanking edges and saturation; zero rows read straight off the format rules
    t_row directed_rows [DIRECTED_ROWS] = '{
        '{KIND_FIVE,    17'd0,      1'b1, "   00", 1'b0},
        '{KIND_ONE_DEC, 17'd0,      1'b1, "  0.0", 1'b0},
        '{KIND_TWO_DEC, 17'd0,      1'b1, " 0.00", 1'b0},
        '{KIND_TEMP,    17'd0,      1'b1, " 00$C", 1'b0},
        '{KIND_FIVE,    17'd99999,  1'b1, "99999", 1'b0},
        '{KIND_ONE_DEC, 17'd99999,  1'b1, "999.9", 1'b0},
        '{KIND_FIVE,    17'd100000, 1'b1, "99999", 1'b1},
        '{KIND_FIVE,    17'd131071, 1'b1, "99999", 1'b1},
        '{KIND_ONE_DEC, 17'd131071, 1'b1, "999.9", 1'b1},
        '{KIND_TWO_DEC, 17'd131071, 1'b1, "99.99", 1'b1},
        '{KIND_TEMP,    17'd131071, 1'b1, "999$C", 1'b1},
        '{KIND_FIVE,    17'd9,      1'b0, 40'd0,   1'b0},
        '{KIND_FIVE,    17'd99,     1'b0, 40'd0,   1'b0},
        '{KIND_FIVE,    17'd100,    1'b0, 40'd0,   1'b0},
        '{KIND_FIVE,    17'd999,    1'b0, 40'd0,   1'b0},
        '{KIND_FIVE,    17'd1000,   1'b0, 40'd0,   1'b0},
        '{KIND_FIVE,    17'd9999,   1'b0, 40'd0,   1'b0},
        '{KIND_FIVE,    17'd10000,  1'b0, 40'd0,   1'b0},
        // ten-thousands dropped: a zero thousands digit must show as '0'
        '{KIND_ONE_DEC, 17'd10000,  1'b0, 40'd0,   1'b0},
        '{KIND_ONE_DEC, 17'd999,    1'b0, 40'd0,   1'b0},
        '{KIND_TWO_DEC, 17'd10005,  1'b0, 40'd0,   1'b0},
        '{KIND_TWO_DEC, 17'd99,     1'b0, 40'd0,   1'b0},
        // temperature field drops the two upper digits
        '{KIND_TEMP,    17'd99,     1'b0, 40'd0,   1'b0},
        '{KIND_TEMP,    17'd100,    1'b0, 40'd0,   1'b0},
        '{KIND_TEMP,    17'd12345,  1'b0, 40'd0,   1'b0}
    };

    decimal_ascii_formatter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_kind     (i_kind),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_char_0   (o_char_0),
        .o_char_1   (o_char_1),
        .o_char_2   (o_char_2),
        .o_char_3   (o_char_3),
        .o_char_4   (o_char_4),
        .o_overflow (o_overflow)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // saturate, split into decimal digits, then lay out the field for the format
    function automatic t_field format_field(input t_kind kind, input logic [16:0] value);
        int unsigned v;
        int unsigned scale;
        logic [7:0]  digit [5];
        logic [7:0]  lead [5];
        t_field      f;
        v     = value;
        f.ovf = 1'b0;
        if (v > VALUE_MAX) begin
            v     = VALUE_MAX;
            f.ovf = 1'b1;
        end
        scale = 1;
        for (int i = 0; i < 5; i++) begin
            digit[i] = ASCII_ZERO + 8'((v / scale) % 10);
            // leading zeros turn into blanks
            lead[i]  = (v < scale) ? ASCII_BLANK : digit[i];
            scale    = scale * 10;
        end
        case (kind)
            KIND_FIVE:    f.text = {lead[4], lead[3], lead[2], digit[1], digit[0]};
            KIND_ONE_DEC: f.text = {lead[3], lead[2], digit[1], ASCII_POINT, digit[0]};
            KIND_TWO_DEC: f.text = {lead[3], digit[2], ASCII_POINT, digit[1], digit[0]};
            default:      f.text = {lead[2], digit[1], digit[0], ASCII_DOLLAR, ASCII_C};
        endcase
        return f;
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT) begin
            $display("mismatch at %0t ns: %s", $time, msg);
        end
        error_count++;
    endtask

    // random value weighted toward digit boundaries and the saturation edge
    function automatic logic [16:0] pick_value();
        int unsigned edges [10] = '{9, 10, 99, 100, 999, 1000, 9999, 10000, 99999, 100000};
        int unsigned sel;
        int unsigned v;
        sel = $urandom_range(99);
        if (sel < 40) begin
            v = $urandom_range(131071);
        end else if (sel < 55) begin
            v = $urandom_range(99);
        end else if (sel < 70) begin
            v = $urandom_range(9999);
        end else if (sel < 90) begin
            v = edges[$urandom_range(9)] + $urandom_range(2) - 1;
        end else begin
            v = $urandom_range(131071, 100000);
        end
        return 17'(v);
    endfunction

    // hold the request until accepted; may idle first, valid stays high otherwise
    task automatic send_request(input t_kind kind, input logic [16:0] value,
                                input t_field want);
        if ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind  <= kind;
        i_value <= value;
        do @(posedge i_clk); while (!o_ready);
        pending_fields.push_back(want);
    endtask

    // receiver: check each accepted result, then choose the next ready level
    always @(posedge i_clk) begin
        t_field      want;
        logic [39:0] got;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_char_0, o_char_1, o_char_2, o_char_3, o_char_4};
            if (pending_fields.size() == 0) begin
                report_mismatch($sformatf("result '%s' with no request pending", got));
            end else begin
                want = pending_fields.pop_front();
                for (int i = 0; i < 5; i++) begin
                    if (got[8*(4-i) +: 8] !== want.text[8*(4-i) +: 8]) begin
                        report_mismatch($sformatf("char_%0d got 0x%02h want 0x%02h (field '%s')",
                            i, got[8*(4-i) +: 8], want.text[8*(4-i) +: 8], want.text));
                    end
                end
                if (o_overflow !== want.ovf) begin
                    report_mismatch($sformatf("overflow got %b want %b (field '%s')",
                        o_overflow, want.ovf, want.text));
                end
            end
        end
        i_ready <= ($urandom_range(99) >= recv_stall);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        t_field want;
        // idle percentages per random phase: sender, receiver
        int     phase_send [RANDOM_PHASES];
        int     phase_recv [RANDOM_PHASES];
        t_kind  kind;

        phase_send = '{0, 58, 0, 34, 0};
        phase_recv = '{0, 0, 58, 34, 0};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, mild idling on both sides
        send_idle  = 20;
        recv_stall = 20;
        foreach (directed_rows[r]) begin
            if (directed_rows[r].typed) begin
                want = '{directed_rows[r].text, directed_rows[r].ovf};
            end else begin
                want = format_field(directed_rows[r].kind, directed_rows[r].value);
            end
            send_request(directed_rows[r].kind, directed_rows[r].value, want);
        end

        // random requests, one idling pattern per phase
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            send_idle  = phase_send[p];
            recv_stall = phase_recv[p];
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                kind = t_kind'($urandom_range(3));
                want = '0;
                begin
                    logic [16:0] v;
                    v    = pick_value();
                    want = format_field(kind, v);
                    send_request(kind, v, want);
                end
            end
        end
        i_valid <= 1'b0;

        // let the pipeline drain, then a few spare cycles for stray results
        while (pending_fields.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
